@@ rtl/spf_pkg.sv @@
// ----------------------------------------------------------------------------
// spf_pkg
// shared types, constants and functions of the space packet framer
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam int MAX_PAYLOAD = 1024;
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int SEQ_W       = 14;
  localparam int HDR_BYTES   = 16;
  localparam int CRC_BYTES   = 2;
  localparam int STEP_W      = $clog2(HDR_BYTES + CRC_BYTES);
  localparam int QDEPTH      = 4;
  localparam int QAW         = $clog2(QDEPTH);

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] MAX_RESET = 16'hFFFF;
  localparam logic [15:0] LEN_BIAS  = 16'd11;

  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_DATA   = 2'd1;
  localparam logic [1:0] MODE_SEQRST = 2'd2;

  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_DATA,
    CMD_ERR
  } cmd_kind_t;

  // one unit of work for the back end; last marks a crc trailer to follow
  typedef struct packed {
    cmd_kind_t        kind;
    logic [10:0]      apid;
    logic             ptype;
    logic [7:0]       subsys;
    logic [31:0]      tick;
    logic [LEN_W-1:0] len;
    logic [7:0]       data;
    logic             last;
    logic [SEQ_W-1:0] seq_hdr;
    logic [SEQ_W-1:0] seq_now;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] hdr_byte(input cmd_t c, input logic [3:0] idx);
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [7:0]  b;
    w0 = {3'b000, c.ptype, 1'b1, c.apid};
    w1 = {2'b11, c.seq_hdr};
    w2 = 16'(c.len) + LEN_BIAS;
    case (idx)
      4'd0:    b = w0[15:8];
      4'd1:    b = w0[7:0];
      4'd2:    b = w1[15:8];
      4'd3:    b = w1[7:0];
      4'd4:    b = w2[15:8];
      4'd5:    b = w2[7:0];
      4'd10:   b = c.tick[31:24];
      4'd11:   b = c.tick[23:16];
      4'd12:   b = c.tick[15:8];
      4'd13:   b = c.tick[7:0];
      4'd14:   b = c.subsys;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/spf_front.sv @@
// ----------------------------------------------------------------------------
// spf_front
// accepts input beats, tracks frame and sequence state, issues commands
// ----------------------------------------------------------------------------
module spf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        mode,
  input  logic [10:0]       apid,
  input  logic              packet_type,
  input  logic [7:0]        subsystem,
  input  logic [31:0]       timestamp,
  input  logic [15:0]       payload_length,
  input  logic [7:0]        data_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data,
  input  logic              q_full,
  output logic              push,
  output spf_pkg::cmd_t     push_cmd
);
  import spf_pkg::*;

  logic [SEQ_W-1:0] seq, seq_next;
  logic [LEN_W-1:0] bytes_left, bytes_left_next;
  logic             frame_active, frame_active_next;
  logic             dropping, dropping_next;
  logic [15:0]      max_frame_bytes;

  logic             accept;
  logic [LEN_W-1:0] len_c;
  logic [LEN_W-1:0] left_dec;
  logic             oversize;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  assign len_c    = (payload_length > 16'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                         : LEN_W'(payload_length);
  assign oversize = (17'(len_c) + 17'(HDR_BYTES + CRC_BYTES)) > {1'b0, max_frame_bytes};
  assign left_dec = bytes_left - LEN_W'(1);

  always_comb begin
    seq_next          = seq;
    bytes_left_next   = bytes_left;
    frame_active_next = frame_active;
    dropping_next     = dropping;
    push              = 1'b0;
    push_cmd          = '0;
    push_cmd.apid     = apid;
    push_cmd.ptype    = packet_type;
    push_cmd.subsys   = subsystem;
    push_cmd.tick     = timestamp;
    push_cmd.len      = len_c;
    push_cmd.data     = data_byte;
    push_cmd.seq_hdr  = seq;
    push_cmd.seq_now  = seq;
    if (accept) begin
      unique case (mode)
        MODE_START: begin
          seq_next          = seq + SEQ_W'(1);
          bytes_left_next   = len_c;
          frame_active_next = (len_c != '0);
          dropping_next     = oversize && (len_c != '0);
          push              = 1'b1;
          push_cmd.kind     = oversize ? CMD_ERR : CMD_HDR;
          push_cmd.last     = (len_c == '0);
          push_cmd.seq_now  = seq + SEQ_W'(1);
        end
        MODE_DATA: begin
          if (frame_active && bytes_left != '0) begin
            bytes_left_next = left_dec;
            if (left_dec == '0) begin
              frame_active_next = 1'b0;
              dropping_next     = 1'b0;
            end
            if (!dropping) begin
              push          = 1'b1;
              push_cmd.kind = CMD_DATA;
              push_cmd.last = (left_dec == '0);
            end
          end
        end
        MODE_SEQRST: begin
          seq_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq             <= '0;
      bytes_left      <= '0;
      frame_active    <= 1'b0;
      dropping        <= 1'b0;
      max_frame_bytes <= MAX_RESET;
    end else begin
      seq          <= seq_next;
      bytes_left   <= bytes_left_next;
      frame_active <= frame_active_next;
      dropping     <= dropping_next;
      if (cfg_valid && cfg_ready) begin
        max_frame_bytes <= cfg_data;
      end
    end
  end

endmodule

@@ rtl/spf_queue.sv @@
// ----------------------------------------------------------------------------
// spf_queue
// small command fifo between front and back
// ----------------------------------------------------------------------------
module spf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  spf_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output spf_pkg::cmd_t head,
  output logic          empty
);
  import spf_pkg::*;

  cmd_t           slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full  = (count == (QAW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        count <= count + (QAW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QAW+1)'(1);
      end
    end
  end

endmodule

@@ rtl/spf_back.sv @@
// ----------------------------------------------------------------------------
// spf_back
// serializes commands into frame bytes, runs the crc, holds the output beat
// ----------------------------------------------------------------------------
module spf_back (
  input  logic                      clk,
  input  logic                      rst,
  input  spf_pkg::cmd_t             head,
  input  logic                      empty,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_byte,
  output logic                      frame_end,
  output logic                      oversize_error,
  output logic [spf_pkg::SEQ_W-1:0] sequence_now
);
  import spf_pkg::*;

  logic [STEP_W-1:0] step;
  logic [15:0]       crc;

  logic              take;
  logic [7:0]        byte_c;
  logic              end_c;
  logic              err_c;
  logic              is_last;
  logic              feed;
  logic [15:0]       base;

  assign take = !empty && (!out_valid || !out_stall);
  assign pop  = take && is_last;

  always_comb begin
    byte_c  = 8'h00;
    end_c   = 1'b0;
    err_c   = 1'b0;
    is_last = 1'b0;
    feed    = 1'b0;
    base    = crc;
    unique case (head.kind)
      CMD_HDR: begin
        if (step < STEP_W'(HDR_BYTES)) begin
          byte_c  = hdr_byte(head, step[3:0]);
          feed    = 1'b1;
          base    = (step == '0) ? CRC_INIT : crc;
          is_last = (step == STEP_W'(HDR_BYTES - 1)) && !head.last;
        end else if (step == STEP_W'(HDR_BYTES)) begin
          byte_c = crc[15:8];
        end else begin
          byte_c  = crc[7:0];
          end_c   = 1'b1;
          is_last = 1'b1;
        end
      end
      CMD_DATA: begin
        if (step == '0) begin
          byte_c  = head.data;
          feed    = 1'b1;
          is_last = !head.last;
        end else if (step == STEP_W'(1)) begin
          byte_c = crc[15:8];
        end else begin
          byte_c  = crc[7:0];
          end_c   = 1'b1;
          is_last = 1'b1;
        end
      end
      CMD_ERR: begin
        end_c   = 1'b1;
        err_c   = 1'b1;
        is_last = 1'b1;
      end
      default: begin
        is_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      crc       <= CRC_INIT;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        step      <= is_last ? '0 : step + STEP_W'(1);
        out_valid <= 1'b1;
        if (feed) begin
          crc <= crc_byte(base, byte_c);
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte       <= byte_c;
      frame_end      <= end_c;
      oversize_error <= err_c;
      sequence_now   <= head.seq_now;
    end
  end

endmodule

@@ rtl/space_packet_framer_crc16.sv @@
// ----------------------------------------------------------------------------
// space_packet_framer_crc16
// space packet framer: 16-byte header, echoed payload, crc-16/ccitt trailer
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              beat content
//  in       input      in_valid / in_stall    mode, apid, packet_type, subsystem,
//                                             timestamp, payload_length, data_byte
//  out      output     out_valid / out_stall  out_byte, frame_end, oversize_error,
//                                             sequence_now
//  cfg      input      cfg_valid / cfg_ready  cfg_data (max_frame_bytes)
//
//  the front takes one input beat per cycle while the 4-entry command queue
//  has room; the back emits one output byte per cycle while out_stall is low
//  a start beat yields 16 header bytes (18 with the crc for an empty payload,
//  a single error beat if oversize), the last payload byte also both crc bytes
//  so header bursts fill the queue and stall the front, payload streams at 1/cycle
//  while out_stall is low; reset (synchronous) clears the sequence count and
//  frame state and sets max_frame_bytes to 65535; there is no clearing pass
//  out_stall holds the output register; the queue decouples the front from it
// ----------------------------------------------------------------------------
module space_packet_framer_crc16 (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                mode,
  input  logic [10:0]               apid,
  input  logic                      packet_type,
  input  logic [7:0]                subsystem,
  input  logic [31:0]               timestamp,
  input  logic [15:0]               payload_length,
  input  logic [7:0]                data_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_byte,
  output logic                      frame_end,
  output logic                      oversize_error,
  output logic [spf_pkg::SEQ_W-1:0] sequence_now,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [15:0]               cfg_data
);
  import spf_pkg::*;

  // command path between front and back
  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  // front: classifies beats, owns sequence count and frame bookkeeping
  spf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .apid           (apid),
    .packet_type    (packet_type),
    .subsystem      (subsystem),
    .timestamp      (timestamp),
    .payload_length (payload_length),
    .data_byte      (data_byte),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .q_full         (q_full),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  // short queue so the front keeps taking beats while the back serializes
  spf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  // back: header/payload/crc byte serializer with registered output
  spf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .empty          (q_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .frame_end      (frame_end),
    .oversize_error (oversize_error),
    .sequence_now   (sequence_now)
  );

  // a command is never written into a full queue
  assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("command pushed into full queue");

  // the back never retires a command that is not there
  assert property (@(posedge clk) disable iff (rst) q_empty |-> !pop)
    else $error("pop from empty command queue");

  // an error beat always closes its frame and carries a zero byte
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && oversize_error) |-> (frame_end && out_byte == 8'h00))
    else $error("malformed oversize error beat");

endmodule
